[hw/rtl/kcg_pkg.sv]
// ----------------------------------------------------------------------------
// kcg_pkg
// Shared types and constants of the k-combination generator: request codes
// and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package kcg_pkg;

    // width of the choose-count register
    localparam int K_W   = 5;
    // width of the position field of a result
    localparam int POS_W = 4;

    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_APPEND = 2'd1,
        FUNC_NEXT   = 2'd2
    } kcg_func_t;

    typedef struct packed {
        logic cfg_write;  // take a new choose count, restart
        logic clear;      // empty the set, restart
        logic append;     // store one element unless the store is full, restart
        logic pos_clear;  // point the read side at position 0
        logic load_elem;  // move the current element into the output register
        logic load_none;  // load the no-combination result
        logic advance;    // step the index vector to the next combination
    } kcg_cmd_t;

    typedef struct packed {
        logic exists;     // a combination can be formed
        logic last_elem;  // current position is the final one of the combination
    } kcg_status_t;

endpackage

[hw/rtl/kcg_ram.sv]
// ----------------------------------------------------------------------------
// kcg_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module kcg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                             aclk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/kcg_datapath.sv]
// ----------------------------------------------------------------------------
// kcg_datapath
// Element store, index vector, count and choose-count registers and the
// output payload register of the k-combination generator.
// ----------------------------------------------------------------------------
module kcg_datapath #(
    parameter int MAX_ELEMENTS  = 64,
    parameter int MAX_CHOOSE    = 16,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  kcg_pkg::kcg_cmd_t           cmd,
    output kcg_pkg::kcg_status_t        status,
    input  logic [kcg_pkg::K_W-1:0]     cfg_data,
    input  logic [ELEMENT_WIDTH-1:0]    element_in,
    output logic [ELEMENT_WIDTH-1:0]    element_out,
    output logic [kcg_pkg::POS_W-1:0]   position,
    output logic                        last_of_combination,
    output logic                        valid_res,
    output logic                        done_res
);

    import kcg_pkg::*;

    localparam int IDX_W = $clog2(MAX_ELEMENTS);
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int CH_W  = (MAX_CHOOSE > 1) ? $clog2(MAX_CHOOSE) : 1;
    localparam int CMP_W = CNT_W + CH_W + K_W;

    logic [K_W-1:0]           k_reg, k_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     finished_reg, finished_next;
    logic [IDX_W-1:0]         idx_reg  [MAX_CHOOSE];
    logic [IDX_W-1:0]         idx_next [MAX_CHOOSE];
    logic [CH_W-1:0]          pos_reg, pos_next;
    logic [CH_W-1:0]          pivot_reg, pivot_next;

    logic [ELEMENT_WIDTH-1:0] elem_out_reg;
    logic [POS_W-1:0]         pos_out_reg;
    logic                     last_reg;
    logic                     valid_reg;
    logic                     done_reg;

    logic [IDX_W-1:0]         rd_idx;
    logic [IDX_W-1:0]         cur_idx;
    logic [IDX_W-1:0]         base_idx;
    logic [ELEMENT_WIDTH-1:0] ram_rdata;
    logic                     ram_we;
    logic                     can_rise;
    logic                     final_combo;
    logic                     done_now;
    logic                     restart;

    function automatic logic combo_ok(input logic [CNT_W-1:0] cnt, input logic [K_W-1:0] k);
        return (cnt != '0) && (k != '0) &&
               (CMP_W'(k) <= CMP_W'(MAX_CHOOSE)) && (CMP_W'(k) <= CMP_W'(cnt));
    endfunction

    assign status.exists    = combo_ok(count_reg, k_reg);
    assign status.last_elem = (CMP_W'(pos_reg) + CMP_W'(1)) == CMP_W'(k_reg);

    assign cur_idx  = (CMP_W'(pos_reg) < CMP_W'(MAX_CHOOSE)) ? idx_reg[pos_reg] : '0;
    assign base_idx = (CMP_W'(pivot_reg) < CMP_W'(MAX_CHOOSE)) ? idx_reg[pivot_reg] : '0;

    // index i can still rise while idx[i] < n - k + i
    assign can_rise    = (CMP_W'(cur_idx) + CMP_W'(k_reg)) <
                         (CMP_W'(count_reg) + CMP_W'(pos_reg));
    // strictly rising vector: first index at its ceiling means all are
    assign final_combo = (CMP_W'(idx_reg[0]) + CMP_W'(k_reg)) == CMP_W'(count_reg);
    assign done_now    = finished_reg | final_combo;

    // read address follows the position of the next cycle, so data lines up
    always_comb begin
        priority if (cmd.pos_clear) begin
            pos_next = '0;
        end else if (cmd.load_elem) begin
            pos_next = pos_reg + CH_W'(1);
        end else begin
            pos_next = pos_reg;
        end
    end

    assign rd_idx = (CMP_W'(pos_next) < CMP_W'(MAX_CHOOSE)) ? idx_reg[pos_next] : '0;
    assign ram_we = cmd.append && (CMP_W'(count_reg) < CMP_W'(MAX_ELEMENTS));

    kcg_ram #(
        .WIDTH (ELEMENT_WIDTH),
        .DEPTH (MAX_ELEMENTS)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (element_in),
        .raddr (rd_idx),
        .rdata (ram_rdata)
    );

    always_comb begin
        k_next        = k_reg;
        count_next    = count_reg;
        finished_next = finished_reg;
        pivot_next    = pivot_reg;
        restart       = 1'b0;
        for (int e = 0; e < MAX_CHOOSE; e++) begin
            idx_next[e] = idx_reg[e];
        end

        if (cmd.cfg_write) begin
            k_next  = cfg_data;
            restart = 1'b1;
        end
        if (cmd.clear) begin
            count_next = '0;
            restart    = 1'b1;
        end
        if (cmd.append) begin
            if (ram_we) begin
                count_next = count_reg + CNT_W'(1);
            end
            restart = 1'b1;
        end
        // rightmost rising index wins as positions are read in order
        if (cmd.load_elem && can_rise) begin
            pivot_next = pos_reg;
        end
        if (cmd.load_none) begin
            finished_next = 1'b1;
        end
        if (cmd.advance && !finished_reg) begin
            if (final_combo) begin
                finished_next = 1'b1;
            end else begin
                for (int e = 0; e < MAX_CHOOSE; e++) begin
                    if ((CMP_W'(e) >= CMP_W'(pivot_reg)) && (CMP_W'(e) < CMP_W'(k_reg))) begin
                        idx_next[e] = IDX_W'(CMP_W'(base_idx) + CMP_W'(e) + CMP_W'(1)
                                             - CMP_W'(pivot_reg));
                    end
                end
            end
        end
        if (restart) begin
            for (int e = 0; e < MAX_CHOOSE; e++) begin
                idx_next[e] = IDX_W'(e);
            end
            finished_next = !combo_ok(count_next, k_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg        <= K_W'(1);
            count_reg    <= '0;
            finished_reg <= 1'b1;
            pos_reg      <= '0;
            pivot_reg    <= '0;
            for (int e = 0; e < MAX_CHOOSE; e++) begin
                idx_reg[e] <= IDX_W'(e);
            end
        end else begin
            k_reg        <= k_next;
            count_reg    <= count_next;
            finished_reg <= finished_next;
            pos_reg      <= pos_next;
            pivot_reg    <= pivot_next;
            for (int e = 0; e < MAX_CHOOSE; e++) begin
                idx_reg[e] <= idx_next[e];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_elem) begin
            elem_out_reg <= ram_rdata;
            pos_out_reg  <= POS_W'(pos_reg);
            last_reg     <= status.last_elem;
            valid_reg    <= 1'b1;
            done_reg     <= done_now;
        end else if (cmd.load_none) begin
            elem_out_reg <= '0;
            pos_out_reg  <= '0;
            last_reg     <= 1'b1;
            valid_reg    <= 1'b0;
            done_reg     <= 1'b1;
        end
    end

    assign element_out         = elem_out_reg;
    assign position            = pos_out_reg;
    assign last_of_combination = last_reg;
    assign valid_res           = valid_reg;
    assign done_res            = done_reg;

endmodule

[hw/rtl/kcg_controller.sv]
// ----------------------------------------------------------------------------
// kcg_controller
// Sequencer of the k-combination generator: takes requests, steps the
// datapath through one combination and owns the output valid flag.
// ----------------------------------------------------------------------------
module kcg_controller (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [1:0]             s_func,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  kcg_pkg::kcg_status_t   status,
    output kcg_pkg::kcg_cmd_t      cmd
);

    import kcg_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_NONE,
        ST_ADVANCE
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE: begin
                cmd.pos_clear = 1'b1;
                if (cfg_valid) begin
                    cmd.cfg_write = 1'b1;
                end
                if (s_tvalid) begin
                    unique case (kcg_func_t'(s_func))
                        FUNC_CLEAR:  cmd.clear  = 1'b1;
                        FUNC_APPEND: cmd.append = 1'b1;
                        FUNC_NEXT:   state_next = status.exists ? ST_EMIT : ST_NONE;
                        default:     ;
                    endcase
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    cmd.load_elem = 1'b1;
                    m_valid_next  = 1'b1;
                    if (status.last_elem) begin
                        state_next = ST_ADVANCE;
                    end
                end
            end
            ST_NONE: begin
                if (out_free) begin
                    cmd.load_none = 1'b1;
                    m_valid_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_ADVANCE: begin
                cmd.advance = 1'b1;
                state_next  = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;

endmodule

[hw/rtl/k_combination_generator_top.sv]
// ----------------------------------------------------------------------------
// k_combination_generator_top
// Loads a set of elements and streams its k-element combinations in
// lexicographic index order.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one request per beat, kind in s_tuser (clear, append, next),
//   the element to append in s_tdata. cfg_ channel writes the choose count k
//   and restarts the enumeration; write it only while the block is idle.
//   m_ channel: a next request yields k beats, one element each, with
//   m_tlast on the final one; if no combination exists, one beat with
//   valid_res low. done_res tells that no further combination follows.
// Timing:
//   clear and append are taken in the idle state. A next request occupies the
//   block for accept, k element reads and index update: the element
//   store has one read port, so elements leave one per cycle while the
//   receiver is ready. The first element is loaded in the emit state.
// Reset: set empty, k = 1, output empty. While the receiver stalls the
//   result waits in the output register and the sequencer holds its place.
// ----------------------------------------------------------------------------
module k_combination_generator_top #(
    parameter int MAX_ELEMENTS  = 64,
    parameter int MAX_CHOOSE    = 16,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // request channel
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((ELEMENT_WIDTH+7)/8)*8-1:0]     s_tdata,   // element_in
    input  logic [1:0]                             s_tuser,   // func
    // choose-count write
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [kcg_pkg::K_W-1:0]                cfg_data,
    // result channel
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((ELEMENT_WIDTH+kcg_pkg::POS_W+1+7)/8)*8-1:0] m_tdata,
                                                   // element_out, position, done_res
    output logic                                   m_tlast,
    output logic                                   m_tuser    // valid_res
);

    import kcg_pkg::*;

    localparam int OUT_W = ((ELEMENT_WIDTH + POS_W + 1 + 7) / 8) * 8;

    kcg_cmd_t                 cmd;
    kcg_status_t              status;
    logic [ELEMENT_WIDTH-1:0] element_out;
    logic [POS_W-1:0]         position;
    logic                     done_res;

    kcg_controller u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_func    (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    kcg_datapath #(
        .MAX_ELEMENTS  (MAX_ELEMENTS),
        .MAX_CHOOSE    (MAX_CHOOSE),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .status              (status),
        .cfg_data            (cfg_data),
        .element_in          (s_tdata[ELEMENT_WIDTH-1:0]),
        .element_out         (element_out),
        .position            (position),
        .last_of_combination (m_tlast),
        .valid_res           (m_tuser),
        .done_res            (done_res)
    );

    assign m_tdata = OUT_W'({done_res, position, element_out});

endmodule

[hw/rtl/kcg_checker.sv]
// ----------------------------------------------------------------------------
// kcg_checker
// Port-level checks of the k-combination generator, bound to the top level.
// ----------------------------------------------------------------------------
module kcg_checker #(
    parameter int ELEMENT_WIDTH = 32
) (
    input logic                                                 aclk,
    input logic                                                 aresetn,
    input logic                                                 s_tvalid,
    input logic                                                 s_tready,
    input logic                                                 cfg_ready,
    input logic                                                 m_tvalid,
    input logic                                                 m_tready,
    input logic [((ELEMENT_WIDTH+kcg_pkg::POS_W+1+7)/8)*8-1:0]  m_tdata,
    input logic                                                 m_tlast,
    input logic                                                 m_tuser
);

    import kcg_pkg::*;

    // stalled beat keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // no-combination beat stands alone and closes the enumeration
    a_none_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast && m_tdata[ELEMENT_WIDTH+POS_W]
        && (m_tdata[ELEMENT_WIDTH+POS_W-1:ELEMENT_WIDTH] == '0))
        else $error("no-combination beat malformed");

    // requests and register writes are taken in the same idle window
    a_cfg_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready |-> s_tready)
        else $error("register write taken while busy");

    // no request is taken while a combination is still streaming out
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> !(m_tvalid && !m_tlast))
        else $error("request taken mid-combination");

    // positions count up within a combination
    a_pos_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> !m_tvalid ||
        (m_tdata[ELEMENT_WIDTH+POS_W-1:ELEMENT_WIDTH]
         == $past(m_tdata[ELEMENT_WIDTH+POS_W-1:ELEMENT_WIDTH]) + POS_W'(1)))
        else $error("position did not step by one");

endmodule

bind k_combination_generator_top kcg_checker #(
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
) u_kcg_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .cfg_ready (cfg_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
);
